// ===== hw/rtl/atpr_pkg.sv =====
// Shared constants, types and functions for the accelerometer tilt block.
`timescale 1ns / 1ps
package atpr_pkg;
	localparam int CordicStepsDef = 16;
	localparam int AngleFracDef = 7;
	localparam int AxisW = 16;
	localparam int CorrW = 17;
	localparam int PitchW = 15;
	localparam int RollW = 16;
	// CORDIC datapath: corrected axis (17b) times 2^12, grown by the gain and by
	// the pass-one magnitude feeding pass two.
	localparam int DataW = 34;
	localparam int AccW = 26;
	localparam int AccFrac = 16;
	localparam int TableLen = 24;
	localparam int InvGain = 39797;
	localparam int Deg90Acc = 5898240;

	typedef enum logic {
		CMD_MEASURE = 1'b0,
		CMD_CALIBRATE = 1'b1
	} cmd_t;

	function automatic logic [AccW-1:0] atan_entry(input logic [4:0] idx);
		logic [AccW-1:0] v;
		case (idx)
			5'd0: v = AccW'(2949120);
			5'd1: v = AccW'(1740967);
			5'd2: v = AccW'(919879);
			5'd3: v = AccW'(466945);
			5'd4: v = AccW'(234379);
			5'd5: v = AccW'(117304);
			5'd6: v = AccW'(58666);
			5'd7: v = AccW'(29335);
			5'd8: v = AccW'(14668);
			5'd9: v = AccW'(7334);
			5'd10: v = AccW'(3667);
			5'd11: v = AccW'(1833);
			5'd12: v = AccW'(917);
			5'd13: v = AccW'(458);
			5'd14: v = AccW'(229);
			5'd15: v = AccW'(115);
			5'd16: v = AccW'(57);
			5'd17: v = AccW'(29);
			5'd18: v = AccW'(14);
			5'd19: v = AccW'(7);
			5'd20: v = AccW'(4);
			5'd21: v = AccW'(2);
			5'd22: v = AccW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

// ===== hw/rtl/accel_tilt_pitch_roll.sv =====
// Top level of the accelerometer tilt block: offsets, sequencing, output register.
// Usage: one input beat carries cmd and three raw 16-bit samples on a valid/ready
// channel. A calibrate beat stores the samples as offsets and returns nothing;
// the block is ready again on the next cycle. A measure beat yields one output
// beat with the corrected axes, pitch and roll in 1/2^ANGLE_FRACTION_BITS degree.
// A measure beat passes through the roll CORDIC pass, a serial gain multiply,
// the pitch CORDIC pass and a rounding step into the output register; the roll
// and pitch passes share the one iterative CORDIC unit. One item is computed at
// a time; the finished result sits in the output register. While the receiver
// stalls, the next beat is still taken and computed, then it waits in the final
// state until the output register frees, and no further beat is taken meanwhile.
// Reset clears the offsets to zero and empties the block.
`timescale 1ns / 1ps
module accel_tilt_pitch_roll import atpr_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef,
	parameter int ANGLE_FRACTION_BITS = AngleFracDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic signed [AxisW-1:0]  accel_x,
	input  logic signed [AxisW-1:0]  accel_y,
	input  logic signed [AxisW-1:0]  accel_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [CorrW-1:0]  corr_x,
	output logic signed [CorrW-1:0]  corr_y,
	output logic signed [CorrW-1:0]  corr_z,
	output logic signed [PitchW-1:0] pitch_angle,
	output logic signed [RollW-1:0]  roll_angle
);
	localparam int Shift = AccFrac - ANGLE_FRACTION_BITS;
	localparam int PitchLim = 90 * (2 ** ANGLE_FRACTION_BITS);
	localparam int RollLim = 180 * (2 ** ANGLE_FRACTION_BITS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_ROLL, ST_GAIN, ST_PITCH, ST_OUT
	} state_t;

	state_t state_q;
	logic signed [AxisW-1:0] off_x_q, off_y_q, off_z_q;
	logic signed [CorrW-1:0] cx_q, cy_q, cz_q;
	logic signed [AccW-1:0] roll_acc_q;
	logic cstart, cdone, gstart, gdone;
	logic signed [DataW-1:0] cx_in, cy_in, cmag, gscaled;
	logic signed [AccW-1:0] cang;
	logic accept;
	logic out_load;
	logic signed [AccW-1:0] pr, rr;
	logic start_q;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	always_comb begin
		if (state_q == ST_ROLL) begin
			cx_in = DataW'(cz_q) <<< 12;
			cy_in = -(DataW'(cx_q) <<< 12);
		end else begin
			cx_in = gscaled;
			cy_in = DataW'(cy_q) <<< 12;
		end
	end

	atpr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(cstart), .x_in(cx_in), .y_in(cy_in),
		.done(cdone), .mag(cmag), .angle(cang)
	);
	atpr_gain u_gain (
		.clk, .arst_n, .start(gstart), .mag(cmag), .done(gdone), .scaled(gscaled)
	);

	assign gstart = (state_q == ST_ROLL) && cdone;

	// Angle rounding: add half an output LSB, then arithmetic shift.
	assign pr = (cang + AccW'(2 ** (Shift - 1))) >>> Shift;
	assign rr = (roll_acc_q + AccW'(2 ** (Shift - 1))) >>> Shift;

	assign cstart = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			off_x_q <= '0; off_y_q <= '0; off_z_q <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			out_valid <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= (accept && (cmd == CMD_MEASURE)) || ((state_q == ST_GAIN) && gdone);
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_CALIBRATE) begin
							off_x_q <= accel_x; off_y_q <= accel_y; off_z_q <= accel_z;
						end else begin
							cx_q <= CorrW'(accel_x) - CorrW'(off_x_q);
							cy_q <= CorrW'(accel_y) - CorrW'(off_y_q);
							cz_q <= CorrW'(accel_z) - CorrW'(off_z_q);
							state_q <= ST_ROLL;
						end
					end
				end
				ST_ROLL: if (cdone) begin
					roll_acc_q <= cang;
					state_q <= ST_GAIN;
				end
				ST_GAIN: if (gdone) state_q <= ST_PITCH;
				ST_PITCH: if (cdone && !start_q) state_q <= ST_OUT;
				ST_OUT: if (out_load) begin
					corr_x <= cx_q;
					corr_y <= cy_q;
					corr_z <= cz_q;
					if (pr > AccW'(PitchLim)) pitch_angle <= PitchW'(PitchLim);
					else if (pr < -AccW'(PitchLim)) pitch_angle <= PitchW'(-PitchLim);
					else pitch_angle <= PitchW'(pr);
					if (rr > AccW'(RollLim)) roll_angle <= RollW'(RollLim);
					else if (rr < -AccW'(RollLim)) roll_angle <= RollW'(-RollLim);
					else roll_angle <= RollW'(rr);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT)) else $error("stray output beat");
	a_gain_after_roll: assert property (@(posedge clk) disable iff (!arst_n)
		gstart |=> (state_q == ST_GAIN)) else $error("gain step out of order");
endmodule

// ===== hw/rtl/atpr_gain.sv =====
// Bit-serial multiply of the pass-one magnitude by the inverse CORDIC gain.
`timescale 1ns / 1ps
module atpr_gain import atpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DataW-1:0]  mag,
	output logic              done,
	output logic [DataW-1:0]  scaled
);
	localparam int GainW = 16;
	localparam int ProdW = DataW + GainW;
	localparam logic [GainW-1:0] Gain = GainW'(InvGain);

	logic [ProdW-1:0] prod_q;
	logic [ProdW-1:0] mcand_q;
	logic [GainW-1:0] mplier_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [ProdW-1:0] rounded;

	// The magnitude is never negative, so plain unsigned shift-add suffices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= busy_q && !start && (cnt_q == 5'(GainW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				prod_q <= '0;
				mcand_q <= ProdW'(mag);
				mplier_q <= Gain;
			end else if (busy_q) begin
				if (mplier_q[0]) prod_q <= prod_q + mcand_q;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(GainW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rounded = prod_q + ProdW'(32768);
	assign scaled = rounded[DataW+15:16];
endmodule

// ===== hw/rtl/atpr_cordic.sv =====
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
`timescale 1ns / 1ps
module atpr_cordic import atpr_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DataW-1:0] x_in,
	input  logic signed [DataW-1:0] y_in,
	output logic                    done,
	output logic signed [DataW-1:0] mag,
	output logic signed [AccW-1:0]  angle
);
	localparam int Steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

	logic signed [DataW-1:0] x_q, y_q;
	logic signed [AccW-1:0] acc_q;
	logic [4:0] i_q;
	logic busy_q;
	logic signed [DataW-1:0] dx, dy;
	logic signed [AccW-1:0] ang;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign ang = $signed(atan_entry(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			// A zero vector finishes at once; otherwise done follows the last step.
			done <= start ? (x_in == '0 && y_in == '0) : (busy_q && i_q == 5'(Steps - 1));
			if (start) begin
				i_q <= '0;
				if (x_in == '0 && y_in == '0) begin
					x_q <= '0; y_q <= '0; acc_q <= '0;
				end else begin
					busy_q <= 1'b1;
					if (x_in < 0 && y_in >= 0) begin
						x_q <= y_in; y_q <= -x_in; acc_q <= AccW'(Deg90Acc);
					end else if (x_in < 0) begin
						x_q <= -y_in; y_q <= x_in; acc_q <= -AccW'(Deg90Acc);
					end else begin
						x_q <= x_in; y_q <= y_in; acc_q <= '0;
					end
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + dx; y_q <= y_q - dy; acc_q <= acc_q + ang;
				end else begin
					x_q <= x_q - dx; y_q <= y_q + dy; acc_q <= acc_q - ang;
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'(Steps - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign mag = x_q;
	assign angle = acc_q;
endmodule

// ===== sim/accel_tilt_pitch_roll_test.sv =====
// Self-checking testbench for the accelerometer tilt block with CORDIC prediction.
`timescale 1ns / 1ps
module accel_tilt_pitch_roll_test;
	import atpr_pkg::*;

	typedef struct {
		cmd_t cmd;
		logic signed [AxisW-1:0] ax;
		logic signed [AxisW-1:0] ay;
		logic signed [AxisW-1:0] az;
	} sample_t;

	typedef struct {
		logic signed [CorrW-1:0] cx;
		logic signed [CorrW-1:0] cy;
		logic signed [CorrW-1:0] cz;
		logic signed [PitchW-1:0] pitch;
		logic signed [RollW-1:0] roll;
	} tilt_t;

	localparam int Steps = 16;
	localparam int FracBits = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic signed [AxisW-1:0] accel_x = '0;
	logic signed [AxisW-1:0] accel_y = '0;
	logic signed [AxisW-1:0] accel_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CorrW-1:0] corr_x;
	logic signed [CorrW-1:0] corr_y;
	logic signed [CorrW-1:0] corr_z;
	logic signed [PitchW-1:0] pitch_angle;
	logic signed [RollW-1:0] roll_angle;

	sample_t pending_samples[$];
	tilt_t expected_tilts[$];
	logic signed [AxisW-1:0] off_x = '0;
	logic signed [AxisW-1:0] off_y = '0;
	logic signed [AxisW-1:0] off_z = '0;
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;

	accel_tilt_pitch_roll uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_deg(int i);
		longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return t[i];
	endfunction

	// Drives y to zero; returns angle in degrees * 2^16 and the gained magnitude.
	function automatic longint cordic_vector(longint x0, longint y0, output longint mag);
		longint x, y, ang, dx, dy, t;
		x = x0;
		y = y0;
		ang = 0;
		mag = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; ang = Deg90Acc;
			end else begin
				x = -y; y = t; ang = -Deg90Acc;
			end
		end
		for (int i = 0; i < Steps; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; ang += atan_deg(i);
			end else begin
				x -= dx; y += dy; ang -= atan_deg(i);
			end
		end
		mag = x;
		return ang;
	endfunction

	function automatic longint angle_out(longint ang, longint lim_deg);
		longint r, lim;
		r = shr_floor(ang + (64'sd1 <<< (AccFrac - FracBits - 1)), AccFrac - FracBits);
		lim = lim_deg <<< FracBits;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	task automatic predict_tilt(sample_t s);
		longint cx, cy, cz, mag_a, mag_b, roll, pitch, m;
		tilt_t e;
		if (s.cmd == CMD_CALIBRATE) begin
			off_x = s.ax; off_y = s.ay; off_z = s.az;
			return;
		end
		cx = longint'(s.ax) - longint'(off_x);
		cy = longint'(s.ay) - longint'(off_y);
		cz = longint'(s.az) - longint'(off_z);
		roll = cordic_vector(cz * 4096, -cx * 4096, mag_a);
		m = (mag_a * InvGain + 32768) >>> 16;
		pitch = cordic_vector(m, cy * 4096, mag_b);
		e.cx = CorrW'(cx);
		e.cy = CorrW'(cy);
		e.cz = CorrW'(cz);
		e.pitch = PitchW'(angle_out(pitch, 90));
		e.roll = RollW'(angle_out(roll, 180));
		expected_tilts.push_back(e);
	endtask

	function automatic logic signed [AxisW-1:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return AxisW'($urandom_range(0, 40) - 20);
			default: return AxisW'($urandom);
		endcase
	endfunction

	function automatic sample_t make_sample(cmd_t c, int x, int y, int z);
		sample_t s;
		s.cmd = c; s.ax = AxisW'(x); s.ay = AxisW'(y); s.az = AxisW'(z);
		return s;
	endfunction

	// Driver: one beat at a time from the pending queue.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_tilt(pending_samples.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					cmd <= pending_samples[0].cmd;
					accel_x <= pending_samples[0].ax;
					accel_y <= pending_samples[0].ay;
					accel_z <= pending_samples[0].az;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_tilts.size() == 0) begin
					$error("unexpected output beat");
					errors++;
				end else begin
					tilt_t e;
					e = expected_tilts.pop_front();
					if (corr_x !== e.cx) begin
						$error("corr_x expected %0d got %0d", e.cx, corr_x); errors++;
					end
					if (corr_y !== e.cy) begin
						$error("corr_y expected %0d got %0d", e.cy, corr_y); errors++;
					end
					if (corr_z !== e.cz) begin
						$error("corr_z expected %0d got %0d", e.cz, corr_z); errors++;
					end
					if (pitch_angle !== e.pitch) begin
						$error("pitch_angle expected %0d got %0d", e.pitch, pitch_angle);
						errors++;
					end
					if (roll_angle !== e.roll) begin
						$error("roll_angle expected %0d got %0d", e.roll, roll_angle);
						errors++;
					end
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() > 0 || in_valid || expected_tilts.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			// Calibrations are kept rare so most beats produce a result.
			pending_samples.push_back(make_sample(
				($urandom_range(0, 9) == 0) ? CMD_CALIBRATE : CMD_MEASURE,
				rand_axis(), rand_axis(), rand_axis()));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vector, axis signs, negative z with zero x, extremes.
		pending_samples.push_back(make_sample(CMD_MEASURE, 0, 0, 0));
		pending_samples.push_back(make_sample(CMD_MEASURE, 0, 0, 16384));
		pending_samples.push_back(make_sample(CMD_MEASURE, 0, 0, -16384));
		pending_samples.push_back(make_sample(CMD_MEASURE, 16384, 0, 0));
		pending_samples.push_back(make_sample(CMD_MEASURE, -16384, 0, 0));
		pending_samples.push_back(make_sample(CMD_MEASURE, 0, 16384, 0));
		pending_samples.push_back(make_sample(CMD_MEASURE, 0, -16384, 0));
		pending_samples.push_back(make_sample(CMD_MEASURE, 100, -200, -300));
		pending_samples.push_back(make_sample(CMD_MEASURE, -100, 200, -300));
		pending_samples.push_back(make_sample(CMD_MEASURE, 32767, 32767, 32767));
		pending_samples.push_back(make_sample(CMD_MEASURE, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(CMD_CALIBRATE, 32767, 32767, 32767));
		pending_samples.push_back(make_sample(CMD_MEASURE, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(CMD_MEASURE, 32767, 32767, 32767));
		pending_samples.push_back(make_sample(CMD_CALIBRATE, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(CMD_MEASURE, 32767, 32767, 32767));
		pending_samples.push_back(make_sample(CMD_MEASURE, -32768, 0, -32768));
		pending_samples.push_back(make_sample(CMD_CALIBRATE, 0, 0, 16384));
		pending_samples.push_back(make_sample(CMD_MEASURE, 5, -7, 16384));
		pending_samples.push_back(make_sample(CMD_CALIBRATE, 0, 0, 0));
		wait_drained();

		queue_random(450);
		wait_drained();
		send_idle_pct = 88;
		queue_random(350);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 88;
		queue_random(350);
		wait_drained();
		send_idle_pct = 25;
		recv_stall_pct = 25;
		queue_random(350);
		// Long receiver hold-off while beats keep coming, so input backs up.
		fork
			begin
				hold_off <= 1'b1;
				repeat (600) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(330);
		wait_drained();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/atpr_pkg.sv
hw/rtl/atpr_gain.sv
hw/rtl/atpr_cordic.sv
hw/rtl/accel_tilt_pitch_roll.sv
sim/accel_tilt_pitch_roll_test.sv
